>>> rtl/b2d_pkg.sv
// Package for the big integer to binary64 converter.
// Holds the fixed format constants and the accumulator state type.
// No dependencies.
`default_nettype none

package b2d_pkg;

    localparam int MAX_EXP_BITS   = 1024;
    localparam int WIN_BITS       = 54;
    localparam int FILL_W         = 6;
    localparam int FRAC_BITS      = 52;
    localparam int EXP_W          = 11;
    localparam int EXP_BIAS_M1    = 1022;
    localparam int DIGIT_BITS_MIN = 16;
    localparam int DIGIT_BITS_MAX = 64;

    // Wide enough for every digit width in the supported range.
    localparam int LEN_W   = $clog2(DIGIT_BITS_MAX + 1);
    localparam int COUNT_W = $clog2(MAX_EXP_BITS / DIGIT_BITS_MIN + 3);

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = {EXP_W{1'b1}};

    typedef struct packed {
        logic [WIN_BITS-1:0] window;
        logic [FILL_W-1:0]   fill;
        logic                sticky;
        logic [LEN_W-1:0]    top_length;
        logic [COUNT_W-1:0]  digit_count;
        logic                sign;
        logic                seen_nonzero;
    } acc_t;

endpackage

`default_nettype wire

>>> rtl/bigint_to_double.sv
// Converts a signed-magnitude integer, streamed one digit per beat with the most
// significant digit first, into an IEEE binary64 pattern rounded to nearest even.
// The block takes one digit every cycle while item_ready is high; a last digit
// waits in the input register until the snapshot is free. A result moves from
// the input register through the accumulator into a snapshot register, then
// through rounding into the result register. Zero gives +0.0 and more than 1024
// significant bits gives signed infinity. DIGIT_BITS may range from 16 to 64.
// Depends on b2d_pkg, b2d_accum and b2d_round.
`default_nettype none

module bigint_to_double #(
    parameter int DIGIT_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire logic [DIGIT_BITS-1:0] digit,
    input  wire logic                  negative,
    input  wire logic                  last,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic [63:0]                bits
);

    logic                  hold_valid_reg;
    logic                  hold_valid_next;
    logic [DIGIT_BITS-1:0] digit_reg;
    logic                  negative_reg;
    logic                  last_reg;

    logic                  snap_valid_reg;
    logic                  snap_valid_next;
    b2d_pkg::acc_t         snap_reg;
    b2d_pkg::acc_t         acc_next;

    logic                  result_valid_reg;
    logic                  result_valid_next;
    logic [63:0]           bits_reg;
    logic [63:0]           round_bits;

    logic                  item_take;
    logic                  step;
    logic                  snap_move;
    logic                  snap_free;

    always_comb
    begin
        snap_move = snap_valid_reg & (~result_valid_reg | result_ready);
        snap_free = ~snap_valid_reg | snap_move;
        // A last digit waits in the input register until the snapshot is free.
        step      = hold_valid_reg & (~last_reg | snap_free);
        item_ready = ~hold_valid_reg | step;
        item_take  = item_valid & item_ready;

        hold_valid_next   = item_take | (hold_valid_reg & ~step);
        snap_valid_next   = (step & last_reg) | (snap_valid_reg & ~snap_move);
        result_valid_next = snap_move | (result_valid_reg & ~result_ready);
    end

    b2d_accum #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .digit    (digit_reg),
        .negative (negative_reg),
        .last     (last_reg),
        .acc_next (acc_next)
    );

    b2d_round #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_round (
        .acc  (snap_reg),
        .bits (round_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            snap_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg   <= hold_valid_next;
            snap_valid_reg   <= snap_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            digit_reg    <= digit;
            negative_reg <= negative;
            last_reg     <= last;
        end
        if (step && last_reg)
        begin
            snap_reg <= acc_next;
        end
        if (snap_move)
        begin
            bits_reg <= round_bits;
        end
    end

    assign result_valid = result_valid_reg;
    assign bits         = bits_reg;

endmodule

`default_nettype wire

>>> rtl/b2d_accum.sv
// Digit accumulator: keeps the top significant bits, sticky, lengths and sign.
// Depends on b2d_pkg.
`default_nettype none

module b2d_accum #(
    parameter int DIGIT_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [DIGIT_BITS-1:0] digit,
    input  wire logic                  negative,
    input  wire logic                  last,
    output b2d_pkg::acc_t              acc_next
);

    localparam int WIN       = b2d_pkg::WIN_BITS;
    localparam int LW        = b2d_pkg::LEN_W;
    localparam int FW        = b2d_pkg::FILL_W;
    localparam int CW        = b2d_pkg::COUNT_W;
    localparam int COUNT_CAP = b2d_pkg::MAX_EXP_BITS / DIGIT_BITS + 2;
    localparam int CAT_W     = WIN + DIGIT_BITS;

    b2d_pkg::acc_t acc_reg;
    logic          in_number_reg;

    logic [FW-1:0]         need;
    logic [LW-1:0]         take;
    logic [LW-1:0]         rest;
    logic [LW-1:0]         len;
    logic [LW-1:0]         lead_shift;
    logic [CAT_W-1:0]      cat_shifted;
    logic [DIGIT_BITS-1:0] rest_mask;
    logic [DIGIT_BITS-1:0] lead_mask;
    logic [DIGIT_BITS-1:0] lead_bits;

    // Bit length of the incoming digit.
    always_comb
    begin
        len = '0;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            if (digit[i])
            begin
                len = LW'(i + 1);
            end
        end
    end

    always_comb
    begin
        need = FW'(WIN) - acc_reg.fill;
        if (LW'(need) > LW'(DIGIT_BITS))
        begin
            take = LW'(DIGIT_BITS);
        end
        else
        begin
            take = LW'(need);
        end
        rest        = LW'(DIGIT_BITS) - take;
        cat_shifted = {acc_reg.window, digit} >> rest;
        rest_mask   = ~({DIGIT_BITS{1'b1}} << rest);

        if (len > LW'(WIN))
        begin
            lead_shift = len - LW'(WIN);
        end
        else
        begin
            lead_shift = '0;
        end
        lead_bits = digit >> lead_shift;
        lead_mask = ~({DIGIT_BITS{1'b1}} << lead_shift);
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (!in_number_reg)
        begin
            acc_next.sign = negative;
        end
        if (acc_reg.seen_nonzero)
        begin
            if (acc_reg.digit_count < CW'(COUNT_CAP))
            begin
                acc_next.digit_count = acc_reg.digit_count + CW'(1);
            end
            if (need == '0)
            begin
                acc_next.sticky = acc_reg.sticky | (|digit);
            end
            else
            begin
                acc_next.window = cat_shifted[WIN-1:0];
                acc_next.sticky = acc_reg.sticky | (|(digit & rest_mask));
                acc_next.fill   = acc_reg.fill + FW'(take);
            end
        end
        else if (|digit)
        begin
            acc_next.seen_nonzero = 1'b1;
            acc_next.top_length   = len;
            acc_next.digit_count  = CW'(1);
            acc_next.window       = WIN'(lead_bits);
            acc_next.sticky       = |(digit & lead_mask);
            if (len > LW'(WIN))
            begin
                acc_next.fill = FW'(WIN);
            end
            else
            begin
                acc_next.fill = FW'(len);
            end
        end
    end

    // The finished number leaves through acc_next; the state starts over.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            in_number_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                acc_reg       <= '0;
                in_number_reg <= 1'b0;
            end
            else
            begin
                acc_reg       <= acc_next;
                in_number_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/b2d_round.sv
// Rounding and packing of a finished accumulator into a binary64 pattern.
// Depends on b2d_pkg.
`default_nettype none

module b2d_round #(
    parameter int DIGIT_BITS = 32
) (
    input  wire b2d_pkg::acc_t acc,
    output logic [63:0]        bits
);

    localparam int WIN       = b2d_pkg::WIN_BITS;
    localparam int CW        = b2d_pkg::COUNT_W;
    localparam int COUNT_CAP = b2d_pkg::MAX_EXP_BITS / DIGIT_BITS + 2;
    localparam int SF_W      = $clog2(DIGIT_BITS * COUNT_CAP + 2);

    logic [WIN-1:0]                 win;
    logic [CW-1:0]                  count_m1;
    logic [SF_W-1:0]                sf;
    logic [SF_W-1:0]                sf_r;
    logic                           up;
    logic [WIN-1:0]                 mant;
    logic [b2d_pkg::FRAC_BITS-1:0]  frac;
    logic [b2d_pkg::EXP_W-1:0]      expo;

    always_comb
    begin
        // Left-align a window that holds fewer bits than its width.
        win      = acc.window << (b2d_pkg::FILL_W'(WIN) - acc.fill);
        count_m1 = acc.digit_count - CW'(1);
        sf       = SF_W'(acc.top_length) + SF_W'(count_m1) * SF_W'(DIGIT_BITS);
        up       = win[0] & (win[1] | acc.sticky);
        mant     = {1'b0, win[WIN-1:1]} + WIN'(up);
        // A carry out leaves exactly the hidden bit, so the fraction is zero.
        if (mant[WIN-1])
        begin
            sf_r = sf + SF_W'(1);
            frac = '0;
        end
        else
        begin
            sf_r = sf;
            frac = mant[b2d_pkg::FRAC_BITS-1:0];
        end
        expo = b2d_pkg::EXP_W'(sf_r + SF_W'(b2d_pkg::EXP_BIAS_M1));

        priority if (!acc.seen_nonzero)
        begin
            bits = '0;
        end
        else if (sf_r > SF_W'(b2d_pkg::MAX_EXP_BITS))
        begin
            bits = {acc.sign, b2d_pkg::EXP_ALL_ONES, {b2d_pkg::FRAC_BITS{1'b0}}};
        end
        else
        begin
            bits = {acc.sign, expo, frac};
        end
    end

endmodule

`default_nettype wire

>>> rtl/b2d_checker.sv
// Port-level checks for bigint_to_double, attached to it by the bind below.
// Depends on bigint_to_double only through its ports.
`default_nettype none

module b2d_checker #(
    parameter int DIGIT_BITS = 32
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  item_valid,
    input wire logic                  item_ready,
    input wire logic [DIGIT_BITS-1:0] digit,
    input wire logic                  negative,
    input wire logic                  last,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire logic [63:0]           bits
);

    // Numbers whose last digit went in but whose result has not been taken.
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       last_in;
    logic       result_out;

    always_comb
    begin
        last_in    = item_valid & item_ready & last;
        result_out = result_valid & result_ready;
        pending_next = pending_reg + 3'(last_in) - 3'(result_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(bits))
        else $error("result changed or dropped while stalled");

    a_result_has_number: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result without a finished number");

    a_pipeline_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more numbers in flight than the pipeline holds");

    a_no_nan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bits[62:52] == 11'h7FF |-> bits[51:0] == 52'd0)
        else $error("NaN pattern produced");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (bits[63:0] == 64'd0) || (bits[62:52] >= 11'd1023))
        else $error("negative zero or fractional exponent produced");

endmodule

bind bigint_to_double b2d_checker #(
    .DIGIT_BITS (DIGIT_BITS)
) u_b2d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .digit        (digit),
    .negative     (negative),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .bits         (bits)
);

`default_nettype wire
